// ===== hdl/dls_pkg.sv =====
package dls_pkg;

	// default geometry
	localparam int unsigned COORD_BITS_DEF = 12;
	localparam int unsigned FRAC_BITS_DEF  = 16;

	// style pattern
	localparam int unsigned PATTERN_LEN = 10;
	localparam int unsigned DASH_ON     = 5;
	localparam int unsigned DOT_SPACING = 4;
	localparam int unsigned PHASE_BITS  = 4;

	typedef logic [PHASE_BITS-1:0] phase_t;

	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STYLE_SIMPLE = 2'd0,
		STYLE_DOTTED = 2'd1,
		STYLE_DASHED = 2'd2,
		STYLE_SOLID  = 2'd3
	} style_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV
	} state_t;

	// strobes from the sequencer to the accumulator unit
	typedef struct packed {
		logic start;
		logic step;
		logic inc_load;
	} accum_ctl_t;

	// flags of the word presented for output
	typedef struct packed {
		logic plot;
		logic large_pt;
		logic last;
		logic active;
	} res_flags_t;

	// divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// whether a step point at this phase is drawn
	function automatic logic pattern_plot(input style_t s, input phase_t p);
		logic r;
		case (s)
			STYLE_DOTTED: r = ((p % DOT_SPACING) == 0);
			STYLE_DASHED: r = (p < DASH_ON);
			default:      r = 1'b1;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/dda_styled_line_stepper.sv =====
// Styled line stepper. Send a start word (opcode 0) with both endpoints and a
// style, then one step word (opcode 1) per point; every word returns exactly
// one result word. The start word returns the start point at once, then the
// block passes a setup state, runs two bit-serial restoring dividers that
// retire one quotient bit per cycle, and then loads the x and y increments;
// in_ready stays low throughout. A zero-length line needs no division and the
// block stays idle. A step word makes one add per axis into the position
// accumulators, so steps flow every cycle while out_ready is high.
// A step word sent with no line in progress reports the held position with all
// flags clear.
module dda_styled_line_stepper #(
	parameter int unsigned COORD_BITS = dls_pkg::COORD_BITS_DEF,
	parameter int unsigned FRAC_BITS  = dls_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         opcode,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	input  logic [1:0]                   style,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] point_x,
	output logic signed [COORD_BITS-1:0] point_y,
	output logic                         plot,
	output logic                         large_res,
	output logic                         last,
	output logic                         active
);
	import dls_pkg::*;

	localparam int unsigned DVD_BITS = COORD_BITS + FRAC_BITS + 1;

	state_t state_q, state_d;
	logic   div_start;

	logic                  accept;
	accum_ctl_t            ctl;

	logic [COORD_BITS:0]   dx;
	logic [COORD_BITS:0]   dy;
	logic [COORD_BITS:0]   dx_neg;
	logic [COORD_BITS:0]   dy_neg;
	logic [COORD_BITS-1:0] adx;
	logic [COORD_BITS-1:0] ady;
	logic [COORD_BITS-1:0] step_cnt;

	logic [COORD_BITS-1:0] adx_q;
	logic [COORD_BITS-1:0] ady_q;
	logic [COORD_BITS-1:0] step_q;
	logic                  negx_q;
	logic                  negy_q;

	logic [DVD_BITS-1:0]   dvd_x;
	logic [DVD_BITS-1:0]   dvd_y;
	logic [DVD_BITS-1:0]   quo_x;
	logic [DVD_BITS-1:0]   quo_y;
	div_stat_t             stat_x;
	div_stat_t             stat_y;
	logic [FRAC_BITS+1:0]  mag_x;
	logic [FRAC_BITS+1:0]  mag_y;
	logic [FRAC_BITS+1:0]  inc_x;
	logic [FRAC_BITS+1:0]  inc_y;

	logic signed [COORD_BITS-1:0] res_x;
	logic signed [COORD_BITS-1:0] res_y;
	res_flags_t                   res_flags;

	logic                  out_valid_q;
	logic [COORD_BITS-1:0] point_x_q;
	logic [COORD_BITS-1:0] point_y_q;
	res_flags_t            flags_q;

	// input handshake
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	// line extent on a start word
	always_comb begin
		dx       = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
		dy       = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
		dx_neg   = -dx;
		dy_neg   = -dy;
		adx      = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
		ady      = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
		step_cnt = (adx > ady) ? adx : ady;
	end

	// operands held for the dividers
	always_ff @(posedge clk) begin
		if (accept && (opcode == OP_START)) begin
			adx_q  <= adx;
			ady_q  <= ady;
			step_q <= step_cnt;
			negx_q <= dx[COORD_BITS];
			negy_q <= dy[COORD_BITS];
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// sequencer next state and strobes
	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		ctl.start    = 1'b0;
		ctl.step     = 1'b0;
		ctl.inc_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (opcode == OP_START) begin
						ctl.start = 1'b1;
						if (step_cnt != '0)
							state_d = ST_LOAD;
					end else begin
						ctl.step = 1'b1;
					end
				end
			end
			ST_LOAD: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (stat_x.done && stat_y.done) begin
					ctl.inc_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// rounded dividends: |d| scaled by the fraction, plus half a step
	assign dvd_x = {1'b0, adx_q, {FRAC_BITS{1'b0}}} + DVD_BITS'(step_q >> 1);
	assign dvd_y = {1'b0, ady_q, {FRAC_BITS{1'b0}}} + DVD_BITS'(step_q >> 1);

	dls_serial_div #(
		.DVD_BITS (DVD_BITS),
		.DVS_BITS (COORD_BITS)
	) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd_x),
		.divisor  (step_q),
		.quotient (quo_x),
		.stat     (stat_x)
	);

	dls_serial_div #(
		.DVD_BITS (DVD_BITS),
		.DVS_BITS (COORD_BITS)
	) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd_y),
		.divisor  (step_q),
		.quotient (quo_y),
		.stat     (stat_y)
	);

	// apply the sign of each axis; the quotient never exceeds one
	always_comb begin
		mag_x = {1'b0, quo_x[FRAC_BITS:0]};
		mag_y = {1'b0, quo_y[FRAC_BITS:0]};
		inc_x = negx_q ? -mag_x : mag_x;
		inc_y = negy_q ? -mag_y : mag_y;
	end

	dls_accum #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.start_x  (start_x),
		.start_y  (start_y),
		.style    (style),
		.step_cnt (step_cnt),
		.inc_x    (inc_x),
		.inc_y    (inc_y),
		.point_x  (res_x),
		.point_y  (res_y),
		.flags    (res_flags)
	);

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (accept)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (accept) begin
			point_x_q <= res_x;
			point_y_q <= res_y;
			flags_q   <= res_flags;
		end
	end

	assign out_valid = out_valid_q;
	assign point_x   = point_x_q;
	assign point_y   = point_y_q;
	assign plot      = flags_q.plot;
	assign large_res = flags_q.large_pt;
	assign last      = flags_q.last;
	assign active    = flags_q.active;

`ifndef SYNTHESIS
	// every accepted word leaves a result word behind
	a_word_out: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted word produced no result");

	// no word is taken while increments are being formed
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("word accepted during increment setup");

	// the dividers run while the sequencer waits on them
	a_div_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (stat_x.busy || stat_x.done))
		else $error("sequencer waiting on an idle divider");

	// both axes finish in the same cycle
	a_div_lock: assert property (@(posedge clk) disable iff (!arst_n)
		(stat_x.done == stat_y.done) && (stat_x.busy == stat_y.busy))
		else $error("axis dividers out of step");

	// a zero-length line never starts the dividers
	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (opcode == OP_START) && (step_cnt == '0)) |=> (state_q == ST_IDLE))
		else $error("zero-length line entered setup");
`endif

endmodule

// ===== hdl/dls_serial_div.sv =====
module dls_serial_div #(
	parameter int unsigned DVD_BITS = dls_pkg::COORD_BITS_DEF + dls_pkg::FRAC_BITS_DEF + 1,
	parameter int unsigned DVS_BITS = dls_pkg::COORD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DVD_BITS-1:0] dividend,
	input  logic [DVS_BITS-1:0] divisor,
	output logic [DVD_BITS-1:0] quotient,
	output dls_pkg::div_stat_t  stat
);
	import dls_pkg::*;

	localparam int unsigned CNT_BITS = $clog2(DVD_BITS + 1);

	logic [DVD_BITS-1:0] dq_q;
	logic [DVS_BITS-1:0] rem_q;
	logic [DVS_BITS-1:0] dvs_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [DVS_BITS:0]   rem_sh;
	logic [DVS_BITS+1:0] diff;
	logic                fits;
	logic [DVS_BITS:0]   rem_nx;

	// one restoring step: bring in the next dividend bit, try the subtract
	always_comb begin
		rem_sh = {rem_q, dq_q[DVD_BITS-1]};
		diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
		fits   = !diff[DVS_BITS+1];
		rem_nx = fits ? diff[DVS_BITS:0] : rem_sh;
	end

	// control of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(DVD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifts out while quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[DVD_BITS-2:0], fits};
			rem_q <= rem_nx[DVS_BITS-1:0];
		end
	end

	assign quotient  = dq_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== hdl/dls_accum.sv =====
module dls_accum #(
	parameter int unsigned COORD_BITS = dls_pkg::COORD_BITS_DEF,
	parameter int unsigned FRAC_BITS  = dls_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dls_pkg::accum_ctl_t         ctl,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic [1:0]                  style,
	input  logic [COORD_BITS-1:0]       step_cnt,
	input  logic signed [FRAC_BITS+1:0] inc_x,
	input  logic signed [FRAC_BITS+1:0] inc_y,
	output logic signed [COORD_BITS-1:0] point_x,
	output logic signed [COORD_BITS-1:0] point_y,
	output dls_pkg::res_flags_t         flags
);
	import dls_pkg::*;

	localparam int unsigned ACC_BITS = COORD_BITS + FRAC_BITS;
	localparam int unsigned EXT_BITS = ACC_BITS - FRAC_BITS - 2;

	logic [ACC_BITS-1:0]   acc_x_q;
	logic [ACC_BITS-1:0]   acc_y_q;
	logic [FRAC_BITS+1:0]  inc_x_q;
	logic [FRAC_BITS+1:0]  inc_y_q;
	logic [COORD_BITS-1:0] steps_left_q;
	phase_t                phase_q;
	style_t                style_q;

	logic [ACC_BITS-1:0]   acc_x_nx;
	logic [ACC_BITS-1:0]   acc_y_nx;
	logic                  running;
	phase_t                phase_nx;

	// truncate toward zero: floor, plus one for a negative value with a fraction
	function automatic logic [COORD_BITS-1:0] trunc_coord(input logic [ACC_BITS-1:0] a);
		logic [COORD_BITS-1:0] hi;
		hi = a[ACC_BITS-1:FRAC_BITS];
		if (a[ACC_BITS-1] && (a[FRAC_BITS-1:0] != '0))
			hi = hi + 1'b1;
		return hi;
	endfunction

	// next position and phase
	always_comb begin
		acc_x_nx = acc_x_q + {{EXT_BITS{inc_x_q[FRAC_BITS+1]}}, inc_x_q};
		acc_y_nx = acc_y_q + {{EXT_BITS{inc_y_q[FRAC_BITS+1]}}, inc_y_q};
		running  = (steps_left_q != '0);
		phase_nx = (phase_q == phase_t'(PATTERN_LEN - 1)) ? '0 : phase_q + 1'b1;
	end

	// word for the item now presented
	always_comb begin
		if (ctl.start) begin
			point_x         = start_x;
			point_y         = start_y;
			flags.plot      = 1'b1;
			flags.large_pt  = (style_t'(style) == STYLE_SOLID);
			flags.last      = (step_cnt == '0);
			flags.active    = 1'b1;
		end else if (running) begin
			point_x         = trunc_coord(acc_x_nx);
			point_y         = trunc_coord(acc_y_nx);
			flags.plot      = pattern_plot(style_q, phase_q);
			flags.large_pt  = (style_q == STYLE_SOLID);
			flags.last      = (steps_left_q == COORD_BITS'(1));
			flags.active    = 1'b1;
		end else begin
			point_x         = trunc_coord(acc_x_q);
			point_y         = trunc_coord(acc_y_q);
			flags.plot      = 1'b0;
			flags.large_pt  = 1'b0;
			flags.last      = 1'b0;
			flags.active    = 1'b0;
		end
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q      <= '0;
			acc_y_q      <= '0;
			inc_x_q      <= '0;
			inc_y_q      <= '0;
			steps_left_q <= '0;
			phase_q      <= '0;
			style_q      <= STYLE_SIMPLE;
		end else if (ctl.start) begin
			acc_x_q      <= {start_x, {FRAC_BITS{1'b0}}};
			acc_y_q      <= {start_y, {FRAC_BITS{1'b0}}};
			inc_x_q      <= '0;
			inc_y_q      <= '0;
			steps_left_q <= step_cnt;
			phase_q      <= '0;
			style_q      <= style_t'(style);
		end else if (ctl.inc_load) begin
			inc_x_q <= inc_x;
			inc_y_q <= inc_y;
		end else if (ctl.step && running) begin
			acc_x_q      <= acc_x_nx;
			acc_y_q      <= acc_y_nx;
			steps_left_q <= steps_left_q - 1'b1;
			phase_q      <= phase_nx;
		end
	end

endmodule
